@@ hw/rtl/normalized_pair_projection_core_assert.svh @@
// Assertion macros for the normalised pair projection core.
`ifndef NORMALIZED_PAIR_PROJECTION_CORE_ASSERT_SVH
`define NORMALIZED_PAIR_PROJECTION_CORE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define NPP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define NPP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ hw/rtl/npp_pkg.sv @@
// Package with shared types and constants of the normalised pair projection core.
`default_nettype none
package npp_pkg;
    localparam int unsigned MaxPairsDefault = 64;
    localparam int unsigned DataW = 32;
    localparam int unsigned AccW  = 64;

    typedef struct packed {
        logic clear;     // clear accumulators
        logic acc;       // accumulate input word
        logic start;     // load root/divide operands
        logic sqrt_step; // one root iteration
        logic div_step;  // one divide iteration
        logic finish;    // form result
    } t_npp_cmd;

    typedef struct packed {
        logic zero;      // square sum is zero
    } t_npp_sts;

    typedef struct packed {
        logic signed [DataW-1:0] chi2_up;
        logic signed [DataW-1:0] chi2_down;
        logic signed [DataW-1:0] pdf_up;
        logic signed [DataW-1:0] pdf_down;
        logic                    last_pair;
    } t_npp_in;

    typedef struct packed {
        logic signed [DataW-1:0] sensitivity;
        logic                    zero_norm;
        logic                    saturated;
    } t_npp_out;
endpackage
`default_nettype wire

@@ hw/rtl/npp_if.sv @@
// Valid/ready channel interface carrying one word of a given payload type.
`default_nettype none
interface npp_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/normalized_pair_projection_core.sv @@
// Top level of the normalised pair projection core.
// A word that is not last runs through S_MUL and S_ACC before the next is accepted.
// A last word then runs the root steps and the divide steps before the result word shows.
// Throughput is set by the shared root and restoring divide units, one bit a cycle.
// Reset is synchronous and active low; it clears the controller and the mode register.
// Accumulators are cleared when each result word is taken and are cleared by reset too.
`default_nettype none
`include "normalized_pair_projection_core_assert.svh"
module normalized_pair_projection_core
    import npp_pkg::*;
#(
    parameter int unsigned MAX_PAIRS = MaxPairsDefault
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_we,
    input  wire logic i_cfg_wdata,
    npp_if.sink       i_in,
    npp_if.source     o_out
);
    logic     r_abs;
    t_npp_cmd w_cmd, w_cmd_dp;
    t_npp_sts w_sts;
    t_npp_out w_res;
    logic     w_in_ready, w_out_valid, w_fire;

    // The user must write the mode register only while the core is idle; the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_abs <= 1'b0;
        else if (i_cfg_we) r_abs <= i_cfg_wdata;
    end

    assign w_fire = i_in.valid && w_in_ready;

    // Reset also clears the running sums so that a new set starts from zero.
    always_comb begin
        w_cmd_dp = w_cmd;
        w_cmd_dp.clear = w_cmd.clear || !i_rst_n;
    end

    npp_ctrl #(.MAX_PAIRS(MAX_PAIRS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(w_fire),
        .i_last(i_in.data.last_pair), .i_out_ready(o_out.ready), .i_sts(w_sts),
        .o_in_ready(w_in_ready), .o_out_valid(w_out_valid), .o_cmd(w_cmd)
    );

    npp_datapath u_dp (
        .i_clk(i_clk), .i_in(i_in.data), .i_abs(r_abs), .i_cmd(w_cmd_dp),
        .o_sts(w_sts), .o_res(w_res)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;
    assign o_out.data  = w_res;

    // The core never takes a word while a result word is on offer.
    `NPP_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, w_out_valid, !w_in_ready)
    // A zero-norm result is never flagged as saturated.
    `NPP_ASSERT_IMP(a_zero_nosat, i_clk, i_rst_n, w_out_valid && w_res.zero_norm,
        !w_res.saturated)
    // After a result is taken the core is ready again.
    `NPP_ASSERT_NXT(a_ready_after, i_clk, i_rst_n, w_out_valid && o_out.ready, w_in_ready)
endmodule
`default_nettype wire

@@ hw/rtl/npp_datapath.sv @@
// Datapath: accumulators, iterative square root and iterative divider.
`default_nettype none
module npp_datapath
    import npp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_npp_in  i_in,
    input  wire logic     i_abs,
    input  wire t_npp_cmd i_cmd,
    output t_npp_sts      o_sts,
    output t_npp_out      o_res
);
    logic signed [AccW-1:0] r_cross;
    logic        [AccW-1:0] r_square;
    logic signed [DataW-1:0] r_dr, r_df;
    logic signed [AccW-1:0] r_pc;
    logic        [AccW-1:0] r_ps;
    // Root state
    logic [AccW-1:0] r_rn, r_res, r_bit;
    // Divide state
    logic [AccW-1:0] r_num, r_rem;
    logic            r_neg;

    logic signed [DataW:0] w_dr33, w_df33;
    logic signed [AccW-1:0] w_pc, w_ps;
    logic signed [AccW:0]  w_csum;
    logic        [AccW:0]  w_ssum;
    logic        [AccW-1:0] w_mag, w_q, w_lim;

    assign w_dr33 = ({i_in.chi2_up[DataW-1], i_in.chi2_up}
                   - {i_in.chi2_down[DataW-1], i_in.chi2_down}) >>> 1;
    assign w_df33 = ({i_in.pdf_up[DataW-1], i_in.pdf_up}
                   - {i_in.pdf_down[DataW-1], i_in.pdf_down}) >>> 1;
    // Full-width signed products of the two halved differences.
    assign w_pc   = r_dr * r_df;
    assign w_ps   = r_df * r_df;
    assign w_csum = {r_cross[AccW-1], r_cross} + {r_pc[AccW-1], r_pc};
    assign w_ssum = {1'b0, r_square} + {1'b0, r_ps};
    assign w_mag  = r_cross[AccW-1] ? (~r_cross + 1'b1) : r_cross;

    // r_pc/r_ps hold the products of r_dr/r_df from the cycle before; acc registers r_dr/r_df, then r_pc/r_ps.
    always_ff @(posedge i_clk) begin
        r_dr <= w_dr33[DataW-1:0];
        r_df <= w_df33[DataW-1:0];
        r_pc <= w_pc;
        r_ps <= w_ps;
        if (i_cmd.clear) begin
            r_cross <= '0;
            r_square <= '0;
        end else if (i_cmd.acc) begin
            if (w_csum[AccW] != w_csum[AccW-1])
                r_cross <= w_csum[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
            else
                r_cross <= w_csum[AccW-1:0];
            r_square <= w_ssum[AccW] ? '1 : w_ssum[AccW-1:0];
        end
        if (i_cmd.start) begin
            r_rn  <= r_square;
            r_res <= '0;
            r_bit <= {2'b01, {(AccW-2){1'b0}}};
            r_num <= w_mag;
            r_rem <= '0;
            r_neg <= r_cross[AccW-1] & ~i_abs;
        end
        if (i_cmd.sqrt_step) begin
            if (r_rn >= r_res + r_bit) begin
                r_rn  <= r_rn - (r_res + r_bit);
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.div_step) begin
            // restoring division; quotient bits shift into r_num
            if ({r_rem, r_num[AccW-1]} >= {1'b0, r_res}) begin
                r_rem <= AccW'({r_rem, r_num[AccW-1]} - {1'b0, r_res});
                r_num <= {r_num[AccW-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[AccW-2:0], r_num[AccW-1]};
                r_num <= {r_num[AccW-2:0], 1'b0};
            end
        end
    end

    assign o_sts.zero = (r_square == '0);
    assign w_q   = r_num;
    assign w_lim = r_neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    always_comb begin
        o_res.zero_norm = o_sts.zero;
        o_res.saturated = 1'b0;
        o_res.sensitivity = '0;
        if (!o_sts.zero) begin
            if (w_q > w_lim) begin
                o_res.saturated = 1'b1;
                o_res.sensitivity = r_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else begin
                o_res.sensitivity = r_neg ? DataW'(~w_q + 1'b1) : w_q[DataW-1:0];
            end
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/npp_ctrl.sv @@
// Controller: sequences accumulation, root, divide and output of one word.
`default_nettype none
module npp_ctrl
    import npp_pkg::*;
#(
    parameter int unsigned MAX_PAIRS = MaxPairsDefault
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_fire,
    input  wire logic     i_last,
    input  wire logic     i_out_ready,
    input  wire t_npp_sts i_sts,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output t_npp_cmd      o_cmd
);
    localparam int unsigned CntW = $clog2(MAX_PAIRS + 1);
    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_ACC, S_SQRT, S_DIV, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic [5:0]      r_step, n_step;
    logic            r_fin, n_fin;

    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_step = r_step; n_fin = r_fin;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_fire) begin
                    n_state = S_MUL;
                    n_cnt = r_cnt + 1'b1;
                    n_fin = i_last || (r_cnt + 1'b1 >= CntW'(MAX_PAIRS));
                end
            end
            S_MUL: n_state = S_ACC;
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state = r_fin ? S_SQRT : S_IDLE;
                n_step = '0;
            end
            S_SQRT: begin
                if (r_step == 6'd0) o_cmd.start = 1'b1;
                else o_cmd.sqrt_step = 1'b1;
                n_step = r_step + 1'b1;
                if (r_step == 6'd32) begin n_step = '0; n_state = S_DIV; end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step = r_step + 1'b1;
                if (r_step == 6'd63) n_state = S_DONE;
            end
            S_DONE: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.clear = 1'b1;
                    n_cnt = '0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_cnt <= '0; r_step <= '0; r_fin <= 1'b0;
        end else begin
            r_state <= n_state; r_cnt <= n_cnt; r_step <= n_step; r_fin <= n_fin;
        end
    end
    logic unused;
    assign unused = i_sts.zero;
endmodule
`default_nettype wire

@@ test/npp_checker.sv @@
// Checker for the normalised pair projection core: predicts result words and compares them.
module npp_checker
    import npp_pkg::*;
#(
    parameter int unsigned MAX_PAIRS = MaxPairsDefault
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  t_npp_in       i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  t_npp_out      i_out_data,
    output int            o_errors,
    output int            o_pending
);
    logic                   abs_mode;
    logic signed [63:0]     cross_acc;
    logic        [63:0]     square_acc;
    int unsigned            pairs_seen;
    t_npp_out               result_queue[$];

    assign o_pending = result_queue.size();

    task automatic report(input string what);
        $display("mismatch: %s", what);
        o_errors++;
    endtask

    function automatic logic signed [63:0] half_diff(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
        logic signed [63:0] d;
        d = 64'(a) - 64'(b);
        return d >>> 1;
    endfunction

    function automatic logic [63:0] int_root(input logic [63:0] n);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    task automatic absorb_pair(input t_npp_in w);
        logic signed [63:0] dr, df, prod, s;
        logic        [63:0] sq, us, mag, q, root;
        logic               neg, last;
        t_npp_out           r;
        dr = half_diff(w.chi2_up, w.chi2_down);
        df = half_diff(w.pdf_up, w.pdf_down);
        prod = dr * df;
        sq = 64'(df * df);
        s = cross_acc + prod;
        if (prod > 0 && s < cross_acc) s = 64'h7fff_ffff_ffff_ffff;
        if (prod < 0 && s > cross_acc) s = 64'h8000_0000_0000_0000;
        cross_acc = s;
        us = square_acc + sq;
        square_acc = (us < square_acc) ? '1 : us;
        pairs_seen++;
        last = w.last_pair || pairs_seen >= MAX_PAIRS;
        if (last) begin
            r = '0;
            if (square_acc == 0) begin
                r.zero_norm = 1'b1;
            end else begin
                root = int_root(square_acc);
                neg = cross_acc < 0;
                mag = neg ? -cross_acc : cross_acc;
                q = mag / root;
                if (abs_mode) neg = 1'b0;
                if (neg) begin
                    if (q > 64'h8000_0000) begin
                        q = 64'h8000_0000;
                        r.saturated = 1'b1;
                    end
                    r.sensitivity = 32'(-q);
                end else begin
                    if (q > 64'h7fff_ffff) begin
                        q = 64'h7fff_ffff;
                        r.saturated = 1'b1;
                    end
                    r.sensitivity = q[31:0];
                end
            end
            result_queue = {result_queue, r};
            cross_acc = 0;
            square_acc = 0;
            pairs_seen = 0;
        end
    endtask

    always @(posedge i_clk) begin
        t_npp_out e;
        if (!i_rst_n) begin
            abs_mode   <= 1'b0;
            cross_acc  = 0;
            square_acc = 0;
            pairs_seen = 0;
            result_queue.delete();
        end else begin
            if (i_cfg_we) abs_mode <= i_cfg_wdata;
            if (i_out_valid && i_out_ready) begin
                if (result_queue.size() == 0) begin
                    report("result word with nothing expected");
                end else begin
                    e = result_queue.pop_front();
                    if (i_out_data.sensitivity !== e.sensitivity)
                        report($sformatf("sensitivity %h, expected %h",
                                         i_out_data.sensitivity, e.sensitivity));
                    if (i_out_data.zero_norm !== e.zero_norm)
                        report($sformatf("zero_norm %b, expected %b",
                                         i_out_data.zero_norm, e.zero_norm));
                    if (i_out_data.saturated !== e.saturated)
                        report($sformatf("saturated %b, expected %b",
                                         i_out_data.saturated, e.saturated));
                end
            end
            if (i_in_valid && i_in_ready) absorb_pair(i_in_data);
        end
    end

    initial o_errors = 0;
endmodule

@@ test/tb_top.sv @@
// Testbench top for the normalised pair projection core: stimulus, reset and verdict.
module tb_top;
    import npp_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_wdata = 1'b0;
    int   errors;
    int   pending;
    int   cycles = 0;
    // Idle percentage for both sides, and a receiver hold-off counted here.
    int   idle_pct = 17;
    int   hold_cycles = 0;

    npp_if #(.T(t_npp_in))  in_ch ();
    npp_if #(.T(t_npp_out)) out_ch ();

    normalized_pair_projection_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    npp_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid (in_ch.valid),
        .i_in_ready (in_ch.ready),
        .i_in_data  (in_ch.data),
        .i_out_valid(out_ch.valid),
        .i_out_ready(out_ch.ready),
        .i_out_data (out_ch.data),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    // The run is capped well above the slowest correct run: every word last, each result
    // running the root and divide steps, plus stalls and idle gaps.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 600000) begin
            $display("[normalized_pair_projection_core] ERROR");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off while hold_cycles runs down.
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Interesting field values: the extremes, values near zero, and otherwise random words.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            4: return 32'(int'($urandom_range(131072)) - 65536);
            default: return $urandom;
        endcase
    endfunction

    // Offers one word and waits until it is taken. Gaps are random at the rate gap_pct gives.
    // Valid stays high after the word is taken; the next word or a gap replaces it.
    task automatic send_word(input t_npp_in w, input int gap_pct);
        while ($urandom_range(99) < gap_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= w;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_pair(input logic [31:0] cu, input logic [31:0] cd,
                             input logic [31:0] pu, input logic [31:0] pd,
                             input logic last, input int gap_pct);
        t_npp_in w;
        w.chi2_up = cu;
        w.chi2_down = cd;
        w.pdf_up = pu;
        w.pdf_down = pd;
        w.last_pair = last;
        send_word(w, gap_pct);
    endtask

    // Waits until every expected result has arrived, then lets the root and divide
    // latency pass, so the mode register is only written with the block idle.
    task automatic drain_and_settle();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // A random set: mostly short, sometimes long enough to reach the pair limit.
    task automatic send_set(input int gap_pct);
        int len;
        len = ($urandom_range(19) == 0) ? $urandom_range(70, 64) : $urandom_range(6, 1);
        for (int k = 0; k < len; k++)
            send_pair(pick_value(), pick_value(), pick_value(), pick_value(),
                      k == len - 1, gap_pct);
    endtask

    initial begin
        int sent;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words in the reset mode: extremes, a zero square sum, saturation.
        send_pair(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 0);
        send_pair(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 0);
        send_pair(32'h0001_0000, 32'h0000_0000, 32'h1234_5678, 32'h1234_5678, 1'b1, 0);
        send_pair(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000, 1'b1, 0);
        send_pair(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'h0000_0000, 1'b1, 0);
        send_pair(32'h0000_0003, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0000, 1'b0, 0);
        send_pair(32'hffff_fffd, 32'h0000_0000, 32'h0002_0000, 32'h0000_0000, 1'b1, 0);
        // Accumulator saturation: many maximum cross products in one set.
        for (int k = 0; k < 8; k++)
            send_pair(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                      k == 7, 0);
        // Pair limit: no last flag for a whole set.
        for (int k = 0; k < 64; k++)
            send_pair($urandom, $urandom, $urandom, $urandom, 1'b0, 0);
        drain_and_settle();

        write_mode(1'b1);
        send_pair(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 0);
        send_pair(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'h0000_0000, 1'b1, 0);
        send_pair(32'hffff_0000, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 1'b1, 0);

        // Random sets, with the mode toggled between phases.
        sent = 0;
        for (int phase = 0; phase < 6; phase++) begin
            drain_and_settle();
            write_mode(phase[0]);
            // The third phase runs with no idling on either side.
            idle_pct = (phase == 2) ? 0 : 17;
            if (phase == 4) begin
                // Long hold-off at the receiver while words keep coming.
                hold_cycles <= 3000;
            end
            for (int s = 0; s < 27; s++) send_set(idle_pct);
        end
        drain_and_settle();
        @(posedge i_clk);

        if (errors == 0) begin
            $display("[normalized_pair_projection_core] OK");
        end else begin
            $display("[normalized_pair_projection_core] ERROR");
        end
        $finish;
    end
endmodule
